// File: rtl/core/m3inv_pkg.sv
// ============================================================================
// m3inv_pkg
// shared constants, table and types for the 3x3 adjugate inverse pipeline
// ============================================================================
package m3inv_pkg;

    localparam int IN_WIDTH_DEF  = 16;
    localparam int OUT_WIDTH_DEF = 32;
    localparam int NUM_EL        = 9;

    // source element indexes (column-major) for cof = x[a]*x[b] - x[c]*x[d]
    localparam int COF_IDX [NUM_EL][4] = '{
        '{8, 4, 5, 7}, '{2, 7, 8, 1}, '{5, 1, 2, 4},
        '{5, 6, 8, 3}, '{8, 0, 2, 6}, '{2, 3, 5, 0},
        '{7, 3, 4, 6}, '{1, 6, 7, 0}, '{4, 0, 1, 3}
    };

    // per-element control carried alongside the quotient
    typedef struct packed {
        logic neg;   // result is negative
        logic sat;   // force saturation by sign
        logic zero;  // force zero
    } lane_ctl_t;

endpackage

// File: rtl/core/m3inv_div.sv
// ============================================================================
// m3inv_div
// pipelined restoring divider, one quotient bit per register stage
// ============================================================================
module m3inv_div
    import m3inv_pkg::*;
#(
    parameter int DW = 51,
    parameter int QW = 32
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [DW-1:0]       d_in,
    input  logic [DW-1:0]       r_in,
    input  logic [QW-1:0]       lq_in,
    input  lane_ctl_t           ctl_in,
    output logic [QW-1:0]       q_out,
    output lane_ctl_t           ctl_out
);

    logic [DW-1:0] d_reg   [QW];
    logic [DW-1:0] r_reg   [QW];
    logic [QW-1:0] lq_reg  [QW];
    lane_ctl_t     ctl_reg [QW];

    logic [DW-1:0] d_src   [QW];
    logic [DW-1:0] r_src   [QW];
    logic [QW-1:0] lq_src  [QW];
    lane_ctl_t     ctl_src [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0]   t;
        logic          ge;
        logic [DW:0]   diff;

        if (s == 0) begin : g_first
            assign d_src[s]   = d_in;
            assign r_src[s]   = r_in;
            assign lq_src[s]  = lq_in;
            assign ctl_src[s] = ctl_in;
        end else begin : g_next
            assign d_src[s]   = d_reg[s-1];
            assign r_src[s]   = r_reg[s-1];
            assign lq_src[s]  = lq_reg[s-1];
            assign ctl_src[s] = ctl_reg[s-1];
        end

        // shift next dividend bit in, trial subtract
        assign t    = {r_src[s], lq_src[s][QW-1]};
        assign ge   = t >= {1'b0, d_src[s]};
        assign diff = t - {1'b0, d_src[s]};

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[s]   <= d_src[s];
                r_reg[s]   <= ge ? diff[DW-1:0] : t[DW-1:0];
                lq_reg[s]  <= {lq_src[s][QW-2:0], ge};
                ctl_reg[s] <= ctl_src[s];
            end
        end
    end

    assign q_out   = lq_reg[QW-1];
    assign ctl_out = ctl_reg[QW-1];

endmodule

// File: rtl/core/matrix3_inverse_cofactor.sv
// ============================================================================
// matrix3_inverse_cofactor
// 3x3 matrix inverse by adjugate, exact rounded division, fully pipelined
// ============================================================================
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: nine source elements
//  m_        out  m_tvalid/m_tready    m_tdata: nine inverse elements,
//                                      m_tuser: singular flag
//  cfg_      in   cfg_valid/cfg_ready  cfg_data: flag_singular
//
//  one matrix per cycle while no result waits on m_tready; the divider
//  resolves one quotient bit per stage
//  aresetn is synchronous, active low; it clears the valid bits and sets
//  flag_singular
//  the whole pipeline holds together when a result waits on m_tready
// ============================================================================
module matrix3_inverse_cofactor
    import m3inv_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2
    input  logic [((NUM_EL*IN_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // inv_r0c0, inv_r1c0, inv_r2c0, inv_r0c1, ..., inv_r2c2
    output logic [((NUM_EL*OUT_WIDTH+7)/8)*8-1:0]  m_tdata,
    // singular
    output logic [0:0]                             m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_data
);

    localparam int IW   = IN_WIDTH;
    localparam int OW   = OUT_WIDTH;
    localparam int PW   = 2*IW;              // element product
    localparam int CW   = 2*IW + 1;          // cofactor
    localparam int DPW  = IW + CW;           // determinant term
    localparam int DW   = DPW + 2;           // determinant
    localparam int FRAC = IW/2 + OW/2;
    localparam int NW   = ((CW + FRAC > DW) ? CW + FRAC : DW) + 1;
    localparam int NHW  = NW - OW;
    localparam int CMPW = (NHW > DW) ? NHW : DW;
    localparam int ODW  = ((NUM_EL*OW+7)/8)*8;

    // global advance: everything moves unless a result is stuck at the output
    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration register
    logic flag_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b1;
        end else if (cfg_valid) begin
            flag_reg <= cfg_data;
        end
    end

    // unpack source elements
    logic signed [IW-1:0] x [NUM_EL];
    for (genvar k = 0; k < NUM_EL; k++) begin : g_unpack
        assign x[k] = s_tdata[k*IW +: IW];
    end

    // valid line through the front stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: cofactor products
    logic signed [PW-1:0] pa_reg [NUM_EL];
    logic signed [PW-1:0] pb_reg [NUM_EL];
    logic signed [IW-1:0] x1_reg [3];
    for (genvar k = 0; k < NUM_EL; k++) begin : g_s1
        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[k] <= x[COF_IDX[k][0]] * x[COF_IDX[k][1]];
                pb_reg[k] <= x[COF_IDX[k][2]] * x[COF_IDX[k][3]];
            end
        end
    end

    // stage 2: cofactors
    logic signed [CW-1:0] cof2_reg [NUM_EL];
    logic signed [IW-1:0] x2_reg [3];
    for (genvar k = 0; k < NUM_EL; k++) begin : g_s2
        always_ff @(posedge aclk) begin
            if (en) begin
                cof2_reg[k] <= CW'(pa_reg[k]) - CW'(pb_reg[k]);
            end
        end
    end

    // stage 3: determinant terms along the first column
    logic signed [DPW-1:0] dp3_reg [3];
    logic signed [CW-1:0]  cof3_reg [NUM_EL];

    // stage 4: determinant
    logic signed [DW-1:0]  det4_reg;
    logic signed [CW-1:0]  cof4_reg [NUM_EL];

    for (genvar j = 0; j < 3; j++) begin : g_col
        always_ff @(posedge aclk) begin
            if (en) begin
                x1_reg[j]  <= x[j];
                x2_reg[j]  <= x1_reg[j];
                dp3_reg[j] <= x2_reg[j] * cof2_reg[3*j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cof3_reg <= cof2_reg;
            cof4_reg <= cof3_reg;
            det4_reg <= DW'(dp3_reg[0]) + DW'(dp3_reg[1]) + DW'(dp3_reg[2]);
        end
    end

    // stage 5: magnitudes, scaled numerator, divider set-up
    logic          dneg;
    logic          dzero;
    logic [DW-1:0] dmag;
    assign dneg  = det4_reg[DW-1];
    assign dzero = (det4_reg == '0);
    assign dmag  = dneg ? DW'(-det4_reg) : DW'(det4_reg);

    logic [DW-1:0] dmag5_reg;
    logic          sing5_reg;
    logic [DW-1:0] r5_reg   [NUM_EL];
    logic [OW-1:0] lq5_reg  [NUM_EL];
    lane_ctl_t     ctl5_reg [NUM_EL];

    for (genvar k = 0; k < NUM_EL; k++) begin : g_s5
        logic            cneg;
        logic            czero;
        logic [CW-1:0]   cmag;
        logic [NW-1:0]   num;
        logic [CMPW-1:0] hi_ext;
        logic            ovf;
        lane_ctl_t       ctl_next;

        assign cneg   = cof4_reg[k][CW-1];
        assign czero  = (cof4_reg[k] == '0);
        assign cmag   = cneg ? CW'(-cof4_reg[k]) : CW'(cof4_reg[k]);
        // |cof| * 2^FRAC plus half the divisor, for round to nearest
        assign num    = (NW'(cmag) << FRAC) + NW'(dmag >> 1);
        assign hi_ext = CMPW'(num[NW-1:OW]);
        // quotient would not fit in OW bits
        assign ovf    = hi_ext >= CMPW'(dmag);

        always_comb begin
            ctl_next.neg  = cneg ^ dneg;
            ctl_next.sat  = dzero ? (!flag_reg && !czero) : ovf;
            ctl_next.zero = dzero && (flag_reg || czero);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r5_reg[k]   <= hi_ext[DW-1:0];
                lq5_reg[k]  <= num[OW-1:0];
                ctl5_reg[k] <= ctl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag5_reg <= dmag;
            sing5_reg <= dzero;
        end
    end

    // division lanes
    logic [OW-1:0] q_div   [NUM_EL];
    lane_ctl_t     ctl_div [NUM_EL];
    for (genvar k = 0; k < NUM_EL; k++) begin : g_div
        m3inv_div #(
            .DW (DW),
            .QW (OW)
        ) u_div (
            .aclk    (aclk),
            .en      (en),
            .d_in    (dmag5_reg),
            .r_in    (r5_reg[k]),
            .lq_in   (lq5_reg[k]),
            .ctl_in  (ctl5_reg[k]),
            .q_out   (q_div[k]),
            .ctl_out (ctl_div[k])
        );
    end

    // valid and singular travel beside the divider
    logic dv_reg   [OW];
    logic dsg_reg  [OW];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int i = 0; i < OW; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int i = 1; i < OW; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dsg_reg[0] <= sing5_reg;
            for (int i = 1; i < OW; i++) begin
                dsg_reg[i] <= dsg_reg[i-1];
            end
        end
    end

    // output format: sign, saturation, forced cases
    localparam logic [OW-1:0] PMAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] NMIN = {1'b1, {(OW-1){1'b0}}};

    logic [ODW-1:0] tdata_next;
    always_comb begin
        tdata_next = '0;
        for (int k = 0; k < NUM_EL; k++) begin
            if (ctl_div[k].zero) begin
                tdata_next[k*OW +: OW] = '0;
            end else if (ctl_div[k].sat) begin
                tdata_next[k*OW +: OW] = ctl_div[k].neg ? NMIN : PMAX;
            end else if (ctl_div[k].neg) begin
                tdata_next[k*OW +: OW] = (q_div[k] > NMIN) ? NMIN : OW'(-q_div[k]);
            end else begin
                tdata_next[k*OW +: OW] = (q_div[k] > PMAX) ? PMAX : q_div[k];
            end
        end
    end

    // output register
    logic           m_tvalid_reg;
    logic [ODW-1:0] m_tdata_reg;
    logic           m_tuser_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_reg[OW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= dsg_reg[OW-1];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// File: rtl/core/m3inv_chk.sv
// ============================================================================
// m3inv_chk
// port-level checks for the 3x3 inverse pipeline, bound to the top level
// ============================================================================
module m3inv_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [287:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // a waiting result stays offered
    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a waiting result keeps its payload
    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side is ready exactly when the pipeline advances
    a_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

    // reset empties the output
    a_reset : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind matrix3_inverse_cofactor m3inv_chk u_m3inv_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker
// watches the matrix, result and flag_singular channels, predicts the exact
// rounded inverse of each accepted matrix and compares it with the results
// ----------------------------------------------------------------------------
module m3inv_checker
    import m3inv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [8:0][31:0] el;
        logic             sing;
    } inverse_t;

    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    string el_name [9] = '{"inv_r0c0", "inv_r1c0", "inv_r2c0", "inv_r0c1", "inv_r1c1",
                           "inv_r2c1", "inv_r0c2", "inv_r1c2", "inv_r2c2"};

    inverse_t expected_inverses[$];
    logic     zero_on_singular;

    function automatic inverse_t predict_inverse(logic [143:0] d, logic zero_flag);
        logic signed [127:0] x [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic [127:0] dmag, cmag, q;
        logic neg;
        inverse_t r;
        for (int k = 0; k < 9; k++)
            x[k] = {{112{d[16*k+15]}}, d[16*k +: 16]};
        for (int k = 0; k < 9; k++)
            cof[k] = x[COF_IDX[k][0]] * x[COF_IDX[k][1]] - x[COF_IDX[k][2]] * x[COF_IDX[k][3]];
        det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
        r.sing = (det == 0);
        dmag = det < 0 ? -det : det;
        for (int k = 0; k < 9; k++) begin
            if (det == 0) begin
                if (zero_flag || cof[k] == 0)
                    r.el[k] = '0;
                else
                    r.el[k] = cof[k] < 0 ? NEG_MAX : POS_MAX;
            end else begin
                cmag = cof[k] < 0 ? -cof[k] : cof[k];
                // 8 input plus 16 output fraction bits
                q    = ((cmag << 24) + (dmag >> 1)) / dmag;
                neg  = (cof[k] < 0) != (det < 0);
                if (neg)
                    r.el[k] = q > 128'h8000_0000 ? NEG_MAX : 32'(-q);
                else
                    r.el[k] = q > 128'h7fff_ffff ? POS_MAX : q[31:0];
            end
        end
        return r;
    endfunction

    assign pending = expected_inverses.size();

    always @(posedge aclk) begin
        inverse_t want;
        if (!aresetn) begin
            zero_on_singular <= 1'b1;
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                zero_on_singular <= cfg_data;
            if (s_tvalid && s_tready)
                expected_inverses.push_back(predict_inverse(s_tdata, zero_on_singular));
            if (m_tvalid && m_tready) begin
                if (expected_inverses.size() == 0) begin
                    $error("result transaction with no matrix outstanding");
                    fail_count++;
                end else begin
                    want = expected_inverses.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[32*k +: 32] !== want.el[k]) begin
                            $error("%s expected %h actual %h", el_name[k], want.el[k],
                                   m_tdata[32*k +: 32]);
                            fail_count++;
                        end
                    if (m_tuser[0] !== want.sing) begin
                        $error("singular expected %b actual %b", want.sing, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_matrix3_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// tb_matrix3_inverse_cofactor
// drives directed and random matrices under both flag_singular settings with
// random input gaps and result backpressure; m3inv_checker judges every result
// ----------------------------------------------------------------------------
module tb_matrix3_inverse_cofactor;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic [143:0] s_tdata;   // m_r0c0, m_r1c0, m_r2c0, m_r0c1, ..., m_r2c2
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] m_tdata;   // inv_r0c0, inv_r1c0, inv_r2c0, ..., inv_r2c2
    logic [0:0]   m_tuser;   // singular
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    int           fail_count;
    int           pending;

    // gaps on both sides are switched off during one long stretch
    bit           gaps_on = 1'b1;
    int           matrices_sent = 0;
    int           flag_writes = 0;

    matrix3_inverse_cofactor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    m3inv_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls of the receiver
    initial m_tready = 1'b0;
    always @(posedge aclk)
        m_tready <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;

    // send one matrix (column-major elements) as one transaction
    task automatic send_matrix(input logic [8:0][15:0] el);
        if (gaps_on && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= el;
        do @(posedge aclk); while (!s_tready);
        matrices_sent++;
    endtask

    // sender holds off until every result is back, then the pipe flushes
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_flag(input logic val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        flag_writes++;
    endtask

    function automatic logic [8:0][15:0] diag(input logic [15:0] a, b, c);
        logic [8:0][15:0] m;
        m    = '0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    // corner matrices: identity, zero, extremes, rank-deficient, tiny det
    task automatic send_directed;
        logic [8:0][15:0] m;
        send_matrix(diag(16'h0100, 16'h0100, 16'h0100));
        send_matrix('0);
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix(diag(16'h8000, 16'h8000, 16'h8000));
        send_matrix(diag(16'h7fff, 16'h7fff, 16'h7fff));
        send_matrix(diag(16'h0001, 16'h0001, 16'h0001));
        send_matrix(diag(16'hffff, 16'h0001, 16'h0001));
        send_matrix(diag(16'h0100, 16'h0100, 16'h0000));
        send_matrix(diag(16'hff00, 16'h0100, 16'h0000));
        send_matrix(diag(16'h0200, 16'hfe00, 16'h0080));
        send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        send_matrix({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                     16'haaaa, 16'h1234, 16'hfedc, 16'h0f0f});
        // first column repeated in the third: singular with mixed cofactors
        m = {16'h0000, 16'h0000, 16'h0000, 16'h0300, 16'hfd00, 16'h0100,
             16'h0100, 16'h0200, 16'hff00};
        m[8:6] = m[2:0];
        send_matrix(m);
        // permutation matrix with negative determinant
        send_matrix({16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0100,
                     16'h0000, 16'h0100, 16'h0000, 16'h0000});
    endtask

    function automatic logic [8:0][15:0] random_matrix;
        logic [8:0][15:0] m;
        int sel;
        int i, j;
        sel = $urandom_range(99);
        for (int k = 0; k < 9; k++)
            m[k] = 16'($urandom());
        if (sel < 20) begin
            // small elements near unity scale
            for (int k = 0; k < 9; k++)
                m[k] = 16'($signed($urandom_range(1024)) - 512);
        end else if (sel < 40) begin
            // often singular: each element of one column copies another column's or is zero
            i = $urandom_range(2);
            j = (i + $urandom_range(1, 2)) % 3;
            for (int r = 0; r < 3; r++)
                m[3*j + r] = ($urandom_range(3) == 0) ? 16'h0000 : m[3*i + r];
        end else if (sel < 55) begin
            // diagonal-heavy, well conditioned
            for (int k = 0; k < 9; k++)
                if (k % 4 != 0) m[k] = 16'($signed($urandom_range(128)) - 64);
        end else if (sel < 62) begin
            // extremes sprinkled in
            for (int k = 0; k < 9; k++)
                if ($urandom_range(1)) m[k] = $urandom_range(1) ? 16'h7fff : 16'h8000;
        end
        return m;
    endfunction

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        aresetn   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of flag_singular first, then both settings explicitly
        send_directed();
        write_flag(1'b0);
        send_directed();
        write_flag(1'b1);
        send_directed();

        for (int phase = 0; phase < 5; phase++) begin
            write_flag(phase[0] ? 1'b1 : 1'b0);
            gaps_on = (phase != 2);
            for (int n = 0; n < 300; n++)
                send_matrix(random_matrix());
        end
        gaps_on = 1'b1;

        drain();
        $display("sent %0d matrices over %0d flag_singular writes, both settings",
                 matrices_sent, flag_writes);
        $display("covered singular, saturating and backpressured cases");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
